// ===== rtl/simbc_pkg.sv =====
// Shared types and constants for the minimal big-endian integer codec.
// Used by every module under rtl/; depends on nothing.
package simbc_pkg;

   localparam int ValueWidth = 64;
   localparam int MaxBytes   = 8;
   localparam int CountWidth = 4;
   localparam int CmdDepth   = 4;

   localparam logic [CountWidth-1:0] TooLongMark = CountWidth'(MaxBytes + 1);

   // request kinds
   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // result kinds
   localparam logic RES_BYTE  = 1'b0;
   localparam logic RES_VALUE = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic signed [ValueWidth-1:0]  value_in;
      logic [7:0]                    in_byte;
      logic                          in_last;
   } req_pkt_type;

   typedef struct packed {
      logic                          res_kind;
      logic [7:0]                    out_byte;
      logic                          out_last;
      logic signed [ValueWidth-1:0]  value_out;
      logic [CountWidth-1:0]         byte_count;
      logic                          too_long;
   } rsp_pkt_type;

   // one unit of work for the back end: a whole encode or one decoded value
   typedef struct packed {
      logic                          kind;
      logic [ValueWidth-1:0]         value;
      logic [CountWidth-1:0]         count;
      logic                          too_long;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // fewest bytes whose sign extension gives back v
   function automatic logic [CountWidth-1:0] min_bytes(input logic [ValueWidth-1:0] v);
      logic [CountWidth-1:0]        n;
      logic signed [ValueWidth-1:0] hi;
      n = CountWidth'(MaxBytes);
      for (int i = MaxBytes - 1; i >= 1; i--) begin
         // bits above the kept bytes' sign bit must all match the sign
         hi = $signed(v) >>> (8 * i - 1);
         if (hi == {ValueWidth{v[ValueWidth-1]}}) begin
            n = CountWidth'(i);
         end
      end
      return n;
   endfunction

   // sign-extend the low n bytes of acc, n in 1..8
   function automatic logic [ValueWidth-1:0] sext_bytes(input logic [ValueWidth-1:0] acc,
                                                        input logic [CountWidth-1:0] n);
      logic [ValueWidth-1:0] val;
      val = acc;
      for (int i = 1; i < MaxBytes; i++) begin
         if (n == CountWidth'(i)) begin
            val = ValueWidth'($signed(acc << (ValueWidth - 8 * i)) >>> (ValueWidth - 8 * i));
         end
      end
      return val;
   endfunction

endpackage

// ===== rtl/signed_int_min_byte_codec_top.sv =====
// Top level of the minimal two's-complement big-endian integer codec.
// Depends on simbc_pkg, simbc_front, simbc_cmd_fifo and simbc_back.
//
// Usage:
//   Request channel (push/full/req_data): a request is taken at a clock edge with push
//   high and full low. An encode request (req_type 0) carries value_in; a decode request
//   (req_type 1) carries one byte in_byte with in_last marking the integer's final byte.
//   Result channel (empty/pop/rsp_data): the oldest result sits on rsp_data while empty
//   is low and is taken at an edge with pop high.
//   An encode yields 1 to 8 byte results, most significant first, out_last on the last.
//   A decode yields one value result on its last byte, none on the others; more than
//   eight bytes gives too_long with value and count zero.
// Flow:
//   A taken request is written into the command queue and moved from there into the
//   result register. The back end emits one result per cycle while a command is queued
//   and the result register is empty or popped. The front end keeps taking requests
//   while the four-entry command queue has room, so full rises only when that queue fills.
// Reset: synchronous, active high; clears the decode accumulator, the queue and the
//   result valid flag. When the receiver stalls, the result register holds, the queue
//   fills behind it, and then full is raised.
module signed_int_min_byte_codec_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  simbc_pkg::req_pkt_type req_data,
   output logic                   empty,
   input  logic                   pop,
   output simbc_pkg::rsp_pkt_type rsp_data
);

   simbc_pkg::cmd_type       push_cmd;
   simbc_pkg::cmd_type       head_cmd;
   simbc_pkg::fifo_stat_type stat;
   logic                     req_accept;
   logic                     cmd_push;
   logic                     cmd_pop;

   // take a request only when the command queue has room
   assign full       = stat.full;
   assign req_accept = push && !stat.full;

   simbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_accept),
      .req_pkt   (req_data),
      .cmd_push  (cmd_push),
      .cmd_pkt   (push_cmd)
   );

   simbc_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_en  (cmd_push),
      .push_cmd (push_cmd),
      .pop_en   (cmd_pop),
      .head_cmd (head_cmd),
      .stat     (stat)
   );

   simbc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .stat     (stat),
      .pop_en   (cmd_pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/simbc_front.sv =====
// Front end of the codec: accepts requests, sizes encodes, gathers decode bytes.
// Depends on simbc_pkg; feeds simbc_cmd_fifo.
module simbc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  simbc_pkg::req_pkt_type req_pkt,
   output logic                  cmd_push,
   output simbc_pkg::cmd_type    cmd_pkt
);

   logic [simbc_pkg::ValueWidth-1:0] accum_ff, accum_in;
   logic [simbc_pkg::CountWidth-1:0] count_ff, count_in;
   logic [simbc_pkg::ValueWidth-1:0] acc_next;
   logic [simbc_pkg::CountWidth-1:0] cnt_next;
   logic                             is_decode;

   assign is_decode = (req_pkt.req_type == simbc_pkg::REQ_DECODE);

   always_comb begin
      acc_next = {accum_ff[simbc_pkg::ValueWidth-9:0], req_pkt.in_byte};
      cnt_next = (count_ff < simbc_pkg::TooLongMark) ? count_ff + 1'b1 : count_ff;
   end

   always_comb begin
      accum_in = accum_ff;
      count_in = count_ff;
      cmd_push = 1'b0;
      cmd_pkt  = '0;
      if (!is_decode) begin
         cmd_push       = req_valid;
         cmd_pkt.kind   = simbc_pkg::REQ_ENCODE;
         cmd_pkt.value  = req_pkt.value_in;
         cmd_pkt.count  = simbc_pkg::min_bytes(req_pkt.value_in);
      end else begin
         cmd_pkt.kind = simbc_pkg::REQ_DECODE;
         if (cnt_next > simbc_pkg::CountWidth'(simbc_pkg::MaxBytes)) begin
            cmd_pkt.too_long = 1'b1;
         end else begin
            cmd_pkt.value = simbc_pkg::sext_bytes(acc_next, cnt_next);
            cmd_pkt.count = cnt_next;
         end
         if (req_valid) begin
            if (req_pkt.in_last) begin
               // integer complete: hand off and clear
               cmd_push = 1'b1;
               accum_in = '0;
               count_in = '0;
            end else begin
               accum_in = acc_next;
               count_in = cnt_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         count_ff <= '0;
      end else begin
         accum_ff <= accum_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/simbc_cmd_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on simbc_pkg.
module simbc_cmd_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_en,
   input  simbc_pkg::cmd_type       push_cmd,
   input  logic                     pop_en,
   output simbc_pkg::cmd_type       head_cmd,
   output simbc_pkg::fifo_stat_type stat
);

   localparam int PtrWidth = $clog2(simbc_pkg::CmdDepth);
   localparam int CntWidth = $clog2(simbc_pkg::CmdDepth + 1);

   simbc_pkg::cmd_type  mem_ff [simbc_pkg::CmdDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == CntWidth'(simbc_pkg::CmdDepth));
   assign stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_ptr_in = push_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_en  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_en && !pop_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push_en && pop_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push_en && stat.full && !pop_en))
      else $error("command pushed into a full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop_en && stat.empty))
      else $error("command popped from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push_en && !pop_en) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue fill count did not advance on push");

endmodule

// ===== rtl/simbc_back.sv =====
// Back end of the codec: walks each command out as result items into an output register.
// Depends on simbc_pkg; reads the head of simbc_cmd_fifo.
module simbc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  simbc_pkg::cmd_type       head_cmd,
   input  simbc_pkg::fifo_stat_type stat,
   output logic                     pop_en,
   input  logic                     pop,
   output logic                     empty,
   output simbc_pkg::rsp_pkt_type   rsp_data
);

   logic                           rsp_valid_ff, rsp_valid_in;
   simbc_pkg::rsp_pkt_type         rsp_ff, rsp_in;
   logic [2:0]                     idx_ff, idx_in;
   logic                           load;
   logic                           last_byte;
   logic [2:0]                     sel;
   logic [simbc_pkg::CountWidth-1:0] cnt_m1;

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign load     = !stat.empty && (!rsp_valid_ff || pop);

   always_comb begin
      cnt_m1    = head_cmd.count - 1'b1;
      last_byte = ({1'b0, idx_ff} == cnt_m1);
      sel       = 3'(cnt_m1 - {1'b0, idx_ff});
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      idx_in       = idx_ff;
      pop_en       = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (head_cmd.kind == simbc_pkg::REQ_DECODE) begin
            rsp_in.res_kind   = simbc_pkg::RES_VALUE;
            rsp_in.value_out  = head_cmd.value;
            rsp_in.byte_count = head_cmd.count;
            rsp_in.too_long   = head_cmd.too_long;
            pop_en            = 1'b1;
         end else begin
            rsp_in.res_kind   = simbc_pkg::RES_BYTE;
            rsp_in.out_byte   = head_cmd.value[8 * sel +: 8];
            rsp_in.out_last   = last_byte;
            rsp_in.byte_count = head_cmd.count;
            if (last_byte) begin
               pop_en = 1'b1;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (!stat.empty && head_cmd.kind == simbc_pkg::REQ_ENCODE)
         |-> ({1'b0, idx_ff} < head_cmd.count))
      else $error("encode byte index ran past the byte count");
   assert property (@(posedge clock) disable iff (reset) stat.empty |-> (idx_ff == '0))
      else $error("byte index left nonzero with no command queued");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !pop) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed or vanished");

endmodule

// ===== sim/codec_checker.sv =====
// Checker for the minimal big-endian integer codec: predicts every result from the
// accepted requests and compares the result channel against it field by field.
// Depends on simbc_pkg for the request and result types and the code constants.
module codec_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  simbc_pkg::req_pkt_type req_data,
   input  logic                   empty,
   input  logic                   pop,
   input  simbc_pkg::rsp_pkt_type rsp_data,
   input  logic                   end_of_run,
   output int                     errors,
   output int                     outstanding,
   output int                     checked
);
   import simbc_pkg::*;

   localparam int PrintLimit = 40;

   rsp_pkt_type           due_results[$];
   logic [ValueWidth-1:0] dec_accum;
   logic [CountWidth-1:0] dec_seen;

   task automatic report_failure(input string msg);
      if (errors < PrintLimit) begin
         $display("[%0t] MISMATCH %s", $time, msg);
      end
      errors++;
   endtask

   // shortest length in bytes whose sign extension reproduces v
   function automatic int enc_length(input logic signed [ValueWidth-1:0] v);
      logic signed [ValueWidth-1:0] t;
      int n;
      n = MaxBytes;
      for (int k = MaxBytes - 1; k >= 1; k--) begin
         t = v <<< (ValueWidth - 8 * k);
         t = t >>> (ValueWidth - 8 * k);
         if (t == v) begin
            n = k;
         end
      end
      return n;
   endfunction

   function automatic logic [ValueWidth-1:0] sign_extend(input logic [ValueWidth-1:0] a,
                                                        input int nbytes);
      logic signed [ValueWidth-1:0] t;
      t = a << (ValueWidth - 8 * nbytes);
      return t >>> (ValueWidth - 8 * nbytes);
   endfunction

   task automatic predict_codec(input req_pkt_type r);
      rsp_pkt_type e;
      int n;
      if (r.req_type == REQ_ENCODE) begin
         n = enc_length(r.value_in);
         for (int i = 0; i < n; i++) begin
            e            = '0;
            e.res_kind   = RES_BYTE;
            e.out_byte   = r.value_in[8 * (n - 1 - i) +: 8];
            e.out_last   = (i == n - 1);
            e.byte_count = CountWidth'(n);
            due_results.push_back(e);
         end
      end else begin
         // decode state is untouched by encodes; count saturates at the too-long mark
         dec_accum = {dec_accum[ValueWidth-9:0], r.in_byte};
         if (dec_seen < TooLongMark) begin
            dec_seen++;
         end
         if (r.in_last) begin
            e          = '0;
            e.res_kind = RES_VALUE;
            if (dec_seen > CountWidth'(MaxBytes)) begin
               e.too_long = 1'b1;
            end else begin
               e.value_out  = sign_extend(dec_accum, int'(dec_seen));
               e.byte_count = dec_seen;
            end
            due_results.push_back(e);
            dec_accum = '0;
            dec_seen  = '0;
         end
      end
   endtask

   task automatic check_result(input rsp_pkt_type got);
      rsp_pkt_type want;
      if (due_results.size() == 0) begin
         report_failure($sformatf("result with nothing expected: %h", got));
      end else begin
         want = due_results.pop_front();
         if (got.res_kind !== want.res_kind)
            report_failure($sformatf("result %0d: res_kind %b, expected %b",
                                     checked, got.res_kind, want.res_kind));
         if (got.out_byte !== want.out_byte)
            report_failure($sformatf("result %0d: out_byte %h, expected %h",
                                     checked, got.out_byte, want.out_byte));
         if (got.out_last !== want.out_last)
            report_failure($sformatf("result %0d: out_last %b, expected %b",
                                     checked, got.out_last, want.out_last));
         if (got.value_out !== want.value_out)
            report_failure($sformatf("result %0d: value_out %h, expected %h",
                                     checked, got.value_out, want.value_out));
         if (got.byte_count !== want.byte_count)
            report_failure($sformatf("result %0d: byte_count %0d, expected %0d",
                                     checked, got.byte_count, want.byte_count));
         if (got.too_long !== want.too_long)
            report_failure($sformatf("result %0d: too_long %b, expected %b",
                                     checked, got.too_long, want.too_long));
      end
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_results.delete();
         dec_accum = '0;
         dec_seen  = '0;
         errors    = 0;
         checked   = 0;
      end else begin
         if (pop && !empty) begin
            check_result(rsp_data);
         end
         if (push && !full) begin
            predict_codec(req_data);
         end
         if (end_of_run && due_results.size() != 0) begin
            report_failure($sformatf("%0d results never arrived", due_results.size()));
            due_results.delete();
         end
      end
      outstanding <= due_results.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the minimal big-endian integer codec: clock, reset, request
// stimulus, result-side stalls and the final verdict. Depends on simbc_pkg,
// codec_checker and the codec RTL.
module tb_top;
   import simbc_pkg::*;

   localparam int RequestTarget = 500;     // directed part plus about 480 random
   localparam int CycleLimit    = 400000;  // many times the slowest legal run

   logic        clock;
   logic        reset      = 1'b1;
   logic        push       = 1'b0;
   logic        pop        = 1'b0;
   logic        end_of_run = 1'b0;
   req_pkt_type req_data   = '0;
   logic        full;
   logic        empty;
   rsp_pkt_type rsp_data;

   int errors;
   int outstanding;
   int checked;

   // stimulus bookkeeping for the summary
   int n_sent    = 0;
   int n_enc     = 0;
   int n_dec     = 0;
   int n_ints    = 0;
   int n_long    = 0;
   int burst_left = 1;
   int cycle_count = 0;

   // receiver stall pattern
   logic [15:0] pop_mask;
   int          pop_phase;

   signed_int_min_byte_codec_top DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   codec_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .end_of_run  (end_of_run),
      .errors      (errors),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, outstanding);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: pop follows a 16-bit mask that is redrawn periodically. Some masks
   // never stall, some stall now and then, and some pop only rarely so the command
   // queue fills and full rises. Bit 0 stays set in the sparse case so every stall ends
   // when the mask comes round to bit 0.
   always @(posedge clock) begin
      if (reset) begin
         pop       <= 1'b0;
         pop_phase = 0;
         pop_mask  = '1;
      end else begin
         if (pop_phase % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  pop_mask = '1;
               end
               1: begin
                  pop_mask = 16'($urandom);
               end
               2: begin
                  pop_mask = 16'($urandom) | 16'($urandom);
               end
               default: begin
                  pop_mask = (16'($urandom) & 16'($urandom)) | 16'h0001;
               end
            endcase
         end
         pop       <= pop_mask[pop_phase % 16];
         pop_phase = pop_phase + 1;
      end
   end

   // Present one request and hold it until the block takes it. Gaps come only at the
   // end of a burst, so push is never lowered and raised again in the same step.
   task automatic send_req(input req_pkt_type r);
      req_data <= r;
      push     <= 1'b1;
      do @(posedge clock); while (full);
      n_sent++;
      if (r.req_type == REQ_ENCODE) begin
         n_enc++;
      end else begin
         n_dec++;
         if (r.in_last) begin
            n_ints++;
         end
      end
      burst_left--;
      if (burst_left <= 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 160)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // Fill the fields a request does not use with noise; the block must ignore them.
   function automatic req_pkt_type noise_req();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_pkt_type)-1:0];
   endfunction

   task automatic encode_value(input logic [ValueWidth-1:0] v);
      req_pkt_type r;
      r          = noise_req();
      r.req_type = REQ_ENCODE;
      r.value_in = v;
      send_req(r);
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      req_pkt_type r;
      r          = noise_req();
      r.req_type = REQ_DECODE;
      r.in_byte  = b;
      r.in_last  = last;
      send_req(r);
   endtask

   // Hold off the sender until every expected result has come back.
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Random value that needs about nbytes bytes: sign-extend a random low part.
   function automatic logic [ValueWidth-1:0] rand_value(input int nbytes);
      logic signed [ValueWidth-1:0] t;
      t = {$urandom, $urandom};
      t = t <<< (ValueWidth - 8 * nbytes);
      return t >>> (ValueWidth - 8 * nbytes);
   endfunction

   // Values on either side of a length boundary: +-2^(8k-1) and their neighbors.
   function automatic logic [ValueWidth-1:0] boundary_value();
      logic [ValueWidth-1:0] p;
      p = 64'd1 << (8 * $urandom_range(1, 8) - 1);
      case ($urandom_range(0, 3))
         0: return p;
         1: return p - 1;
         2: return -p;
         default: return -p - 1;
      endcase
   endfunction

   initial begin
      int len;
      bit paused;
      paused = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: length extremes for encode, including zero and minus one.
      encode_value(64'd0);
      encode_value('1);
      encode_value(64'd127);
      encode_value(64'd128);
      encode_value(-64'sd128);
      encode_value(-64'sd129);
      encode_value(64'h7FFF_FFFF_FFFF_FFFF);
      encode_value(64'h8000_0000_0000_0000);
      // single byte with the sign bit set, then a positive two-byte integer
      decode_byte(8'hFF, 1'b1);
      decode_byte(8'h00, 1'b0);
      decode_byte(8'h80, 1'b1);
      // too long: nine bytes with an encode landing in the middle of the decode
      for (int i = 0; i < 9; i++) begin
         decode_byte(8'h80 | 8'(i), i == 8);
         if (i == 3) begin
            encode_value(64'hFFFF_FFFF_FFFF_7F00);
         end
      end
      n_long++;
      drain();

      // Random part: mostly well-formed decode runs and encodes, some raw noise.
      while (n_sent < RequestTarget) begin
         if (!paused && n_sent >= RequestTarget / 2) begin
            drain();
            paused = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if ($urandom_range(0, 7) == 0) begin
                  encode_value(boundary_value());
               end else begin
                  encode_value(rand_value($urandom_range(1, 8)));
               end
            end
            4, 5, 6, 7, 8: begin
               if ($urandom_range(0, 9) == 0) begin
                  len = $urandom_range(9, 12);
                  n_long++;
               end else begin
                  len = $urandom_range(1, 8);
               end
               for (int i = 0; i < len; i++) begin
                  decode_byte(8'($urandom), i == len - 1);
                  // drop an encode into the middle of the run now and then
                  if (i < len - 1 && $urandom_range(0, 6) == 0) begin
                     encode_value(rand_value($urandom_range(1, 8)));
                  end
               end
            end
            default: begin
               send_req(noise_req());
            end
         endcase
      end

      // Wait out every expected result, then keep watching for stray output before the end.
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (16) @(posedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);

      $display("requests: %0d encodes, %0d decode bytes closing %0d integers (%0d too long)",
               n_enc, n_dec, n_ints, n_long);
      $display("results compared: %0d in %0d cycles", checked, cycle_count);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
